[design/newline_run_collapse_filter_assert.svh]
// Assertion macros for the newline run collapse filter.
// Used by nrc_datapath; expects signals named clock and reset in the including module.
`ifndef NEWLINE_RUN_COLLAPSE_FILTER_ASSERT_SVH
`define NEWLINE_RUN_COLLAPSE_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define NRC_ASSERT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("nrc assertion failed");
`define NRC_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("nrc assertion failed");
`else
`define NRC_ASSERT(label, pre, post)
`define NRC_ASSERT_NEXT(label, pre, post)
`endif
`endif

[design/nrc_pkg.sv]
// Shared types and byte constants for the newline run collapse filter.
// No dependencies; used by nrc_ctrl, nrc_datapath and the top level.
package nrc_pkg;

   localparam logic [7:0] BYTE_LF  = 8'h0A;
   localparam logic [7:0] BYTE_CR  = 8'h0D;
   localparam logic [7:0] BYTE_SP  = 8'h20;
   localparam logic [7:0] BYTE_TAB = 8'h09;
   localparam logic [7:0] BYTE_VT  = 8'h0B;
   localparam logic [7:0] BYTE_FF  = 8'h0C;
   localparam logic [7:0] BYTE_C2  = 8'hC2;
   localparam logic [7:0] BYTE_AD  = 8'hAD;
   localparam logic [7:0] BYTE_E2  = 8'hE2;
   localparam logic [7:0] BYTE_81  = 8'h81;
   localparam logic [7:0] BYTE_A0  = 8'hA0;
   localparam logic [7:0] BYTE_80  = 8'h80;
   localparam logic [7:0] BYTE_8B  = 8'h8B;
   localparam logic [7:0] BYTE_8C  = 8'h8C;
   localparam logic [7:0] BYTE_8D  = 8'h8D;
   localparam logic [1:0] TALLY_COMMIT = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FL_READ,
      ST_FL_SEND,
      ST_LIT,
      ST_APPEND,
      ST_FL2_START,
      ST_TAIL
   } nrc_state_type;

   typedef struct packed {
      logic accept;
      logic fast_emit;
      logic fast_write;
      logic fl_read;
      logic fl_send;
      logic fl_load2;
      logic lit_send;
      logic app_write;
      logic tail_send;
   } nrc_cmd_type;

   typedef struct packed {
      logic plan_fl1;
      logic plan_lit;
      logic plan_app;
      logic plan_fl2;
      logic fast_lit;
      logic fast_app;
      logic out_free;
      logic fl_end;
      logic fl_phase2;
      logic lit_more;
      logic app_more;
      logic tail_more;
      logic has_lit;
      logic has_app;
      logic has_fl2;
      logic has_tail;
   } nrc_status_type;

endpackage

[design/nrc_ctrl.sv]
// Sequencer for the newline run collapse filter: steps flush, literal, append, tail phases.
// Depends on nrc_pkg; drives nrc_datapath through nrc_cmd_type.
module nrc_ctrl
   import nrc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  nrc_status_type st,
   output nrc_cmd_type    cmd
);

   nrc_state_type state_ff;
   nrc_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if ((st.fast_lit && st.out_free) || st.fast_app) begin
                  state_in = ST_IDLE;
               end else if (st.plan_fl1) begin
                  state_in = ST_FL_READ;
               end else if (st.plan_lit) begin
                  state_in = ST_LIT;
               end else if (st.plan_app) begin
                  state_in = ST_APPEND;
               end else if (st.plan_fl2) begin
                  state_in = ST_FL_READ;
               end
            end
         end
         ST_FL_READ: state_in = ST_FL_SEND;
         ST_FL_SEND: begin
            if (st.out_free) begin
               if (!st.fl_end) begin
                  state_in = ST_FL_READ;
               end else if (st.fl_phase2) begin
                  state_in = st.has_tail ? ST_TAIL : ST_IDLE;
               end else if (st.has_lit) begin
                  state_in = ST_LIT;
               end else if (st.has_app) begin
                  state_in = ST_APPEND;
               end else if (st.has_fl2) begin
                  state_in = ST_FL2_START;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_LIT: begin
            if (st.out_free && !st.lit_more) begin
               if (st.has_app) begin
                  state_in = ST_APPEND;
               end else if (st.has_fl2) begin
                  state_in = ST_FL2_START;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_APPEND: begin
            if (!st.app_more) begin
               state_in = st.has_fl2 ? ST_FL2_START : ST_IDLE;
            end
         end
         ST_FL2_START: state_in = ST_FL_READ;
         ST_TAIL: begin
            if (st.out_free && !st.tail_more) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready     = 1'b1;
            cmd.accept     = req_tvalid;
            cmd.fast_emit  = req_tvalid && st.fast_lit && st.out_free;
            cmd.fast_write = req_tvalid && st.fast_app;
         end
         ST_FL_READ:   cmd.fl_read   = 1'b1;
         ST_FL_SEND:   cmd.fl_send   = st.out_free;
         ST_LIT:       cmd.lit_send  = st.out_free;
         ST_APPEND:    cmd.app_write = 1'b1;
         ST_FL2_START: cmd.fl_load2  = 1'b1;
         ST_TAIL:      cmd.tail_send = st.out_free;
         default: begin
            cmd        = '0;
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

[design/nrc_datapath.sv]
// Datapath of the newline run collapse filter: run buffer, run state, decode, output register.
// Depends on nrc_pkg and newline_run_collapse_filter_assert.svh; driven by nrc_ctrl.
`include "newline_run_collapse_filter_assert.svh"
module nrc_datapath
   import nrc_pkg::*;
#(
   parameter int RUN_DEPTH = 32
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic [7:0]     req_tdata,
   input  logic           req_tlast,
   input  logic           csr_valid,
   input  logic           csr_data,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [7:0]     rsp_tdata,
   output logic           rsp_tuser,
   output logic           rsp_tlast,
   input  nrc_cmd_type    cmd,
   output nrc_status_type st
);

   localparam int FILL_W = $clog2(RUN_DEPTH + 1);
   localparam int IDX_W  = $clog2(RUN_DEPTH);

   // run state
   logic              enable_ff;
   logic              in_run_ff, in_run_in;
   logic [1:0]        tally_ff, tally_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [1:0]        held_n_ff, held_n_in;
   logic [7:0]        held1_ff, held1_in;
   logic [7:0]        held2_ff, held2_in;

   logic [7:0] run_mem [RUN_DEPTH];
   logic [7:0] rd_data_ff;

   // latched work of the current word
   logic              last_ff;
   logic [2:0][7:0]   lit_q_ff;
   logic [1:0]        lit_n_ff;
   logic [2:0][7:0]   app_q_ff;
   logic [1:0]        app_n_ff;
   logic [FILL_W-1:0] app_base_ff;
   logic              has_fl2_ff;
   logic [FILL_W-1:0] fl2_len_ff;
   logic              fl2_coll_ff;
   logic [1:0][7:0]   tail_q_ff;
   logic [1:0]        tail_n_ff;
   logic [IDX_W-1:0]  fl_idx_ff;
   logic [FILL_W-1:0] fl_len_ff;
   logic              fl_coll_ff;
   logic              fl_phase2_ff;

   logic       rsp_tvalid_ff;
   logic [7:0] rsp_tdata_ff;
   logic       rsp_tuser_ff;
   logic       rsp_tlast_ff;

   // decode
   logic              is_nl, is_sp1;
   logic              p_fl1, p_fl2;
   logic [2:0][7:0]   p_lit;
   logic [1:0]        p_lit_n;
   logic [2:0][7:0]   p_app;
   logic [1:0]        p_app_n;
   logic [FILL_W-1:0] p_base;
   logic [FILL_W-1:0] p_fl2_len;
   logic              restart, do_sep;
   logic [1:0]        pre_n, sep_n;
   logic [2:0][7:0]   sep;
   logic              sep_over;

   logic       out_free;
   logic       emit_valid, emit_final, emit_end;
   logic [7:0] emit_data;
   logic       fl_end;
   logic       mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [7:0] mem_wdata;

   assign is_nl  = (req_tdata == BYTE_CR) || (req_tdata == BYTE_LF);
   assign is_sp1 = (req_tdata == BYTE_SP) || (req_tdata == BYTE_TAB) ||
                   (req_tdata == BYTE_VT) || (req_tdata == BYTE_FF);
   assign sep_over = ({1'b0, fill_ff} + (FILL_W+1)'(sep_n)) > (FILL_W+1)'(RUN_DEPTH);

   always_comb begin
      p_fl1     = 1'b0;
      p_lit     = '0;
      p_lit_n   = 2'd0;
      p_app     = '0;
      p_app_n   = 2'd0;
      p_base    = fill_ff;
      in_run_in = in_run_ff;
      tally_in  = tally_ff;
      held_n_in = held_n_ff;
      held1_in  = held1_ff;
      held2_in  = held2_ff;
      restart   = 1'b0;
      pre_n     = 2'd0;
      do_sep    = 1'b0;
      sep       = '0;
      sep_n     = 2'd0;
      if (!enable_ff) begin
         p_fl1     = in_run_ff;
         p_base    = '0;
         in_run_in = 1'b0;
         tally_in  = 2'd0;
         held_n_in = 2'd0;
         held1_in  = 8'h00;
         held2_in  = 8'h00;
         case (held_n_ff)
            2'd0: begin
               p_lit[0] = req_tdata;
               p_lit_n  = 2'd1;
            end
            2'd1: begin
               p_lit[0] = held1_ff;
               p_lit[1] = req_tdata;
               p_lit_n  = 2'd2;
            end
            default: begin
               p_lit   = {req_tdata, held2_ff, held1_ff};
               p_lit_n = 2'd3;
            end
         endcase
      end else if (!in_run_ff) begin
         if (is_nl) begin
            p_base    = '0;
            p_app[0]  = req_tdata;
            p_app_n   = 2'd1;
            tally_in  = 2'd1;
            in_run_in = 1'b1;
         end else begin
            p_lit[0] = req_tdata;
            p_lit_n  = 2'd1;
         end
      end else begin
         case (held_n_ff)
            2'd0: begin
               if (is_nl) begin
                  if (tally_ff >= 2'd2) begin
                     tally_in = TALLY_COMMIT;
                  end else if (fill_ff >= FILL_W'(RUN_DEPTH)) begin
                     restart = 1'b1;
                  end else begin
                     p_app[0] = req_tdata;
                     p_app_n  = 2'd1;
                     tally_in = tally_ff + 2'd1;
                  end
               end else if (is_sp1) begin
                  do_sep = 1'b1;
                  sep[0] = req_tdata;
                  sep_n  = 2'd1;
               end else if (req_tdata == BYTE_C2 || req_tdata == BYTE_E2) begin
                  held_n_in = 2'd1;
                  held1_in  = req_tdata;
                  held2_in  = 8'h00;
               end else begin
                  restart = 1'b1;
               end
            end
            2'd1: begin
               held_n_in = 2'd0;
               held1_in  = 8'h00;
               held2_in  = 8'h00;
               if (held1_ff == BYTE_C2) begin
                  if (req_tdata == BYTE_AD) begin
                     do_sep = 1'b1;
                     sep    = {8'h00, BYTE_AD, BYTE_C2};
                     sep_n  = 2'd2;
                  end else begin
                     restart = 1'b1;
                     pre_n   = 2'd1;
                  end
               end else if (req_tdata == BYTE_81 || req_tdata == BYTE_80) begin
                  held_n_in = 2'd2;
                  held1_in  = held1_ff;
                  held2_in  = req_tdata;
               end else begin
                  restart = 1'b1;
                  pre_n   = 2'd1;
               end
            end
            default: begin
               held_n_in = 2'd0;
               held1_in  = 8'h00;
               held2_in  = 8'h00;
               if ((held2_ff == BYTE_81 && req_tdata == BYTE_A0) ||
                   (held2_ff == BYTE_80 && (req_tdata == BYTE_8B ||
                    req_tdata == BYTE_8C || req_tdata == BYTE_8D))) begin
                  do_sep = 1'b1;
                  sep    = {req_tdata, held2_ff, held1_ff};
                  sep_n  = 2'd3;
               end else begin
                  restart = 1'b1;
                  pre_n   = 2'd2;
               end
            end
         endcase
      end

      if (do_sep && tally_ff != TALLY_COMMIT) begin
         if (sep_over) begin
            p_fl1     = 1'b1;
            p_base    = '0;
            p_lit     = sep;
            p_lit_n   = sep_n;
            in_run_in = 1'b0;
            tally_in  = 2'd0;
         end else begin
            p_app   = sep;
            p_app_n = sep_n;
         end
      end

      if (restart) begin
         p_fl1     = 1'b1;
         p_base    = '0;
         p_lit     = {8'h00, held2_ff, held1_ff};
         p_lit_n   = pre_n;
         held_n_in = 2'd0;
         held1_in  = 8'h00;
         held2_in  = 8'h00;
         if (is_nl) begin
            p_app[0]  = req_tdata;
            p_app_n   = 2'd1;
            tally_in  = 2'd1;
            in_run_in = 1'b1;
         end else begin
            in_run_in = 1'b0;
            tally_in  = 2'd0;
            p_lit_n   = pre_n + 2'd1;
            case (pre_n)
               2'd0:    p_lit[0] = req_tdata;
               2'd1:    p_lit[1] = req_tdata;
               default: p_lit[2] = req_tdata;
            endcase
         end
      end
   end

   assign p_fl2     = req_tlast && in_run_in;
   assign p_fl2_len = p_base + FILL_W'(p_app_n);
   assign fill_in   = p_fl2 ? '0 : p_fl2_len;

   assign out_free = !rsp_tvalid_ff || rsp_tready;
   // a collapsed run always sends exactly two LF bytes
   assign fl_end   = fl_coll_ff ? (fl_idx_ff == IDX_W'(1))
                                : ((FILL_W'(fl_idx_ff) + FILL_W'(1)) == fl_len_ff);

   always_comb begin
      st           = '0;
      st.plan_fl1  = p_fl1;
      st.plan_lit  = p_lit_n != 2'd0;
      st.plan_app  = p_app_n != 2'd0;
      st.plan_fl2  = p_fl2;
      st.fast_lit  = !p_fl1 && p_lit_n == 2'd1 && p_app_n == 2'd0 && !p_fl2;
      st.fast_app  = !p_fl1 && p_lit_n == 2'd0 && p_app_n == 2'd1 && !p_fl2;
      st.out_free  = out_free;
      st.fl_end    = fl_end;
      st.fl_phase2 = fl_phase2_ff;
      st.lit_more  = lit_n_ff > 2'd1;
      st.app_more  = app_n_ff > 2'd1;
      st.tail_more = tail_n_ff > 2'd1;
      st.has_lit   = lit_n_ff != 2'd0;
      st.has_app   = app_n_ff != 2'd0;
      st.has_fl2   = has_fl2_ff;
      st.has_tail  = tail_n_ff != 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         in_run_ff <= 1'b0;
         tally_ff  <= 2'd0;
         fill_ff   <= '0;
         held_n_ff <= 2'd0;
         held1_ff  <= 8'h00;
         held2_ff  <= 8'h00;
      end else begin
         if (csr_valid) begin
            enable_ff <= csr_data;
         end
         if (cmd.accept) begin
            fill_ff <= fill_in;
            if (p_fl2) begin
               in_run_ff <= 1'b0;
               tally_ff  <= 2'd0;
               held_n_ff <= 2'd0;
               held1_ff  <= 8'h00;
               held2_ff  <= 8'h00;
            end else begin
               in_run_ff <= in_run_in;
               tally_ff  <= tally_in;
               held_n_ff <= held_n_in;
               held1_ff  <= held1_in;
               held2_ff  <= held2_in;
            end
         end
      end
   end

   // work queues
   always_ff @(posedge clock) begin
      if (reset) begin
         lit_n_ff   <= 2'd0;
         app_n_ff   <= 2'd0;
         tail_n_ff  <= 2'd0;
         has_fl2_ff <= 1'b0;
      end else if (cmd.accept) begin
         lit_n_ff   <= cmd.fast_emit ? 2'd0 : p_lit_n;
         app_n_ff   <= cmd.fast_write ? 2'd0 : p_app_n;
         tail_n_ff  <= p_fl2 ? held_n_in : 2'd0;
         has_fl2_ff <= p_fl2;
      end else begin
         if (cmd.lit_send) begin
            lit_n_ff <= lit_n_ff - 2'd1;
         end
         if (cmd.app_write) begin
            app_n_ff <= app_n_ff - 2'd1;
         end
         if (cmd.tail_send) begin
            tail_n_ff <= tail_n_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         last_ff      <= req_tlast;
         lit_q_ff     <= p_lit;
         app_q_ff     <= p_app;
         app_base_ff  <= p_base;
         fl2_len_ff   <= p_fl2_len;
         fl2_coll_ff  <= tally_in == TALLY_COMMIT;
         tail_q_ff    <= {held2_in, held1_in};
         fl_idx_ff    <= '0;
         fl_len_ff    <= p_fl1 ? fill_ff : p_fl2_len;
         fl_coll_ff   <= p_fl1 ? (tally_ff == TALLY_COMMIT) : (tally_in == TALLY_COMMIT);
         fl_phase2_ff <= !p_fl1;
      end else begin
         if (cmd.fl_load2) begin
            fl_idx_ff    <= '0;
            fl_len_ff    <= fl2_len_ff;
            fl_coll_ff   <= fl2_coll_ff;
            fl_phase2_ff <= 1'b1;
         end
         if (cmd.fl_send) begin
            fl_idx_ff <= fl_idx_ff + IDX_W'(1);
         end
         if (cmd.lit_send) begin
            lit_q_ff <= {8'h00, lit_q_ff[2], lit_q_ff[1]};
         end
         if (cmd.app_write) begin
            app_q_ff    <= {8'h00, app_q_ff[2], app_q_ff[1]};
            app_base_ff <= app_base_ff + FILL_W'(1);
         end
         if (cmd.tail_send) begin
            tail_q_ff <= {8'h00, tail_q_ff[1]};
         end
      end
   end

   // run buffer
   assign mem_we    = cmd.fast_write || cmd.app_write;
   assign mem_waddr = cmd.fast_write ? p_base[IDX_W-1:0] : app_base_ff[IDX_W-1:0];
   assign mem_wdata = cmd.fast_write ? p_app[0] : app_q_ff[0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         run_mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.fl_read) begin
         rd_data_ff <= run_mem[fl_idx_ff];
      end
   end

   // output word
   always_comb begin
      emit_valid = 1'b0;
      emit_data  = 8'h00;
      emit_final = 1'b0;
      emit_end   = 1'b0;
      if (cmd.fast_emit) begin
         emit_valid = 1'b1;
         emit_data  = p_lit[0];
         emit_final = 1'b1;
         emit_end   = req_tlast;
      end else if (cmd.fl_send) begin
         emit_valid = 1'b1;
         emit_data  = fl_coll_ff ? BYTE_LF : rd_data_ff;
         emit_final = fl_end && (fl_phase2_ff ? (tail_n_ff == 2'd0)
                                              : (lit_n_ff == 2'd0 && !has_fl2_ff));
         emit_end   = emit_final && last_ff;
      end else if (cmd.lit_send) begin
         emit_valid = 1'b1;
         emit_data  = lit_q_ff[0];
         emit_final = lit_n_ff == 2'd1 && !has_fl2_ff;
         emit_end   = emit_final && last_ff;
      end else if (cmd.tail_send) begin
         emit_valid = 1'b1;
         emit_data  = tail_q_ff[0];
         emit_final = tail_n_ff == 2'd1;
         emit_end   = emit_final && last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (emit_valid) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_valid) begin
         rsp_tdata_ff <= emit_data;
         rsp_tuser_ff <= emit_final;
         rsp_tlast_ff <= emit_end;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   `NRC_ASSERT(a_fill_bound, 1'b1, fill_ff <= FILL_W'(RUN_DEPTH))
   `NRC_ASSERT(a_idle_clear, !in_run_ff, tally_ff == 2'd0 && held_n_ff == 2'd0 && fill_ff == '0)
   `NRC_ASSERT(a_held_range, 1'b1, held_n_ff != 2'd3)
   `NRC_ASSERT(a_emit_slot, emit_valid, !rsp_tvalid_ff || rsp_tready)
   `NRC_ASSERT_NEXT(a_end_clears, emit_valid && emit_end, !in_run_ff && held_n_ff == 2'd0)

endmodule

[design/newline_run_collapse_filter.sv]
// Top level of the newline run collapse filter: UTF-8 byte stream in, sanitized stream out.
// Depends on nrc_pkg, nrc_ctrl and nrc_datapath.
//
//   channel   dir   handshake               payload
//   req_      in    req_tvalid/req_tready   req_tdata = in_byte, req_tlast = text_last
//   rsp_      out   rsp_tvalid/rsp_tready   rsp_tdata = out_byte, rsp_tuser = burst_last,
//                                           rsp_tlast = text_end
//   csr_      in    csr_valid/csr_ready     csr_data = collapse_enable
//
// A byte that passes straight through or adds one byte to a run takes the fast path from the idle state.
// Multi-byte separators are written into the run buffer one byte per cycle.
// A flush of an uncollapsed run reads each byte from the buffer, then sends it;
// a collapsed run also takes a read step and a send step for each of its two LF bytes.
// Reset is synchronous; collapse_enable resets to 1, run buffer contents are not cleared.
// A stalled rsp_ side holds the current word in the output register and pauses the sequencer.
module newline_run_collapse_filter
   import nrc_pkg::*;
#(
   parameter int RUN_DEPTH = 32
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tuser,   // [0] burst_last
   output logic       rsp_tlast,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_data
);

   nrc_cmd_type    cmd;
   nrc_status_type st;

   assign csr_ready = 1'b1;

   nrc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   nrc_datapath #(
      .RUN_DEPTH (RUN_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .st         (st)
   );

endmodule

[verif/newline_run_collapse_filter_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for newline_run_collapse_filter: directed table, then random text.
// Depends on nrc_pkg and the filter RTL; predicts every output word and compares field by field.
module testbench;
   import nrc_pkg::*;

   localparam int RUN_DEPTH     = 32;
   localparam int LIMIT_CYCLES  = 1_000_000;
   localparam int SETTLE_CYCLES = 2 * RUN_DEPTH + 40;

   typedef struct packed {
      logic [7:0] data;
      logic       burst_last;
      logic       text_end;
   } out_word_type;

   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic        typed;
      logic [1:0]  n;
      logic [23:0] outs;   // first byte in the low bits
   } probe_row_type;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;
   logic       rsp_tuser;
   logic       rsp_tlast;
   logic       csr_valid;
   logic       csr_ready;
   logic       csr_data;

   // predictor state
   logic [7:0]  run_store [RUN_DEPTH];
   int unsigned run_len;
   int unsigned nl_count;
   bit          run_open;
   logic [7:0]  hold_hi;
   logic [7:0]  hold_lo;
   int unsigned hold_len;
   bit          collapse_on;
   logic [7:0]  burst_q [$];
   out_word_type expected_words [$];

   // bookkeeping
   int unsigned words_in;
   int unsigned words_out;
   int unsigned csr_writes;
   int unsigned error_count;
   int unsigned cycle_count;
   int unsigned collapse_count;
   int unsigned overflow_count;
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   bit          typed_active;
   probe_row_type typed_row;
   probe_row_type probe_table [24];
   logic [7:0]  segment_bytes [$];

   newline_run_collapse_filter #(.RUN_DEPTH(RUN_DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   function automatic bit is_newline(input logic [7:0] b);
      return b == BYTE_LF || b == BYTE_CR;
   endfunction

   function automatic bit is_blank(input logic [7:0] b);
      return b == BYTE_SP || b == BYTE_TAB || b == BYTE_VT || b == BYTE_FF;
   endfunction

   task automatic burst_add(input logic [7:0] b);
      burst_q = {burst_q, b};
   endtask

   task automatic seg_add(input logic [7:0] b);
      segment_bytes = {segment_bytes, b};
   endtask

   task automatic clear_model();
      run_len = 0;
      nl_count = 0;
      run_open = 0;
      hold_hi = '0;
      hold_lo = '0;
      hold_len = 0;
      collapse_on = 1'b1;
   endtask

   task automatic close_run();
      int unsigned i;
      if (nl_count >= TALLY_COMMIT) begin
         burst_add(BYTE_LF);
         burst_add(BYTE_LF);
         collapse_count++;
      end else begin
         for (i = 0; i < run_len; i++) burst_add(run_store[i]);
      end
      run_open = 0;
      run_len = 0;
      nl_count = 0;
   endtask

   task automatic start_or_pass(input logic [7:0] b);
      if (is_newline(b)) begin
         run_open = 1;
         nl_count = 1;
         run_store[0] = b;
         run_len = 1;
      end else begin
         burst_add(b);
      end
   endtask

   task automatic store_sep(input logic [23:0] s, input int unsigned n);
      int unsigned i;
      if (nl_count >= TALLY_COMMIT) return;
      if (run_len + n > RUN_DEPTH) begin
         overflow_count++;
         close_run();
         for (i = 0; i < n; i++) start_or_pass(s[8*i +: 8]);
         return;
      end
      for (i = 0; i < n; i++) begin
         run_store[run_len] = s[8*i +: 8];
         run_len++;
      end
   endtask

   task automatic add_newline(input logic [7:0] b);
      if (nl_count + 1 >= TALLY_COMMIT) begin
         nl_count = TALLY_COMMIT;
         return;
      end
      if (run_len + 1 > RUN_DEPTH) begin
         overflow_count++;
         close_run();
         start_or_pass(b);
         return;
      end
      run_store[run_len] = b;
      run_len++;
      nl_count++;
   endtask

   task automatic take_run_byte(input logic [7:0] b);
      logic [7:0]  first_b;
      logic [7:0]  second_b;
      int unsigned len;
      first_b = hold_hi;
      second_b = hold_lo;
      len = hold_len;
      if (len == 0) begin
         if (is_newline(b)) add_newline(b);
         else if (is_blank(b)) store_sep({16'h0, b}, 1);
         else if (b == BYTE_C2 || b == BYTE_E2) begin
            hold_hi = b;
            hold_lo = '0;
            hold_len = 1;
         end else begin
            close_run();
            start_or_pass(b);
         end
         return;
      end
      hold_len = 0;
      hold_hi = '0;
      hold_lo = '0;
      if (first_b == BYTE_C2) begin
         if (b == BYTE_AD) store_sep({8'h0, BYTE_AD, BYTE_C2}, 2);
         else begin
            close_run();
            burst_add(BYTE_C2);
            start_or_pass(b);
         end
      end else if (len == 1) begin
         if (b == BYTE_81 || b == BYTE_80) begin
            hold_hi = BYTE_E2;
            hold_lo = b;
            hold_len = 2;
         end else begin
            close_run();
            burst_add(BYTE_E2);
            start_or_pass(b);
         end
      end else if ((second_b == BYTE_81 && b == BYTE_A0) ||
                   (second_b == BYTE_80 && (b == BYTE_8B || b == BYTE_8C || b == BYTE_8D))) begin
         store_sep({b, second_b, BYTE_E2}, 3);
      end else begin
         close_run();
         burst_add(BYTE_E2);
         burst_add(second_b);
         start_or_pass(b);
      end
   endtask

   task automatic resolve_run();
      int unsigned len;
      logic [7:0]  hi;
      logic [7:0]  lo;
      if (!run_open) return;
      len = hold_len;
      hi = hold_hi;
      lo = hold_lo;
      hold_len = 0;
      hold_hi = '0;
      hold_lo = '0;
      close_run();
      if (len >= 1) burst_add(hi);
      if (len >= 2) burst_add(lo);
   endtask

   task automatic predict_word(input logic [7:0] b, input logic last);
      int unsigned  k;
      out_word_type w;
      burst_q.delete();
      if (!collapse_on) begin
         resolve_run();
         burst_add(b);
      end else if (run_open) begin
         take_run_byte(b);
      end else begin
         start_or_pass(b);
      end
      if (last) resolve_run();
      if (typed_active && typed_row.typed) begin
         burst_q.delete();
         for (k = 0; k < typed_row.n; k++) burst_add(typed_row.outs[8*k +: 8]);
      end
      for (k = 0; k < burst_q.size(); k++) begin
         w.data       = burst_q[k];
         w.burst_last = k == burst_q.size() - 1;
         w.text_end   = k == burst_q.size() - 1 && last;
         expected_words = {expected_words, w};
      end
   endtask

   task automatic check_word();
      out_word_type want;
      words_out++;
      if (expected_words.size() == 0) begin
         $error("unexpected output word: out_byte %h", rsp_tdata);
         error_count++;
         return;
      end
      want = expected_words.pop_front();
      if (rsp_tdata !== want.data) begin
         $error("out_byte: expected %h, got %h", want.data, rsp_tdata);
         error_count++;
      end
      if (rsp_tuser !== want.burst_last) begin
         $error("burst_last: expected %b, got %b", want.burst_last, rsp_tuser);
         error_count++;
      end
      if (rsp_tlast !== want.text_end) begin
         $error("text_end: expected %b, got %b", want.text_end, rsp_tlast);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_model();
      end else begin
         if (csr_valid && csr_ready) begin
            collapse_on = csr_data;
            csr_writes++;
         end
         if (req_tvalid && req_tready) begin
            predict_word(req_tdata, req_tlast);
            words_in++;
         end
         if (rsp_tvalid && rsp_tready) check_word();
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_tready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);

   task automatic send_word(input logic [7:0] b, input logic last);
      int unsigned seen;
      seen = words_in;
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= last;
      do @(negedge clock); while (words_in == seen);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_enable(input logic value);
      int unsigned seen;
      seen = csr_writes;
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(negedge clock); while (csr_writes == seen);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] any_newline();
      return $urandom_range(0, 1) ? BYTE_LF : BYTE_CR;
   endfunction

   task automatic push_separator();
      case ($urandom_range(0, 6))
         0: seg_add(BYTE_SP);
         1: seg_add(BYTE_TAB);
         2: seg_add(BYTE_VT);
         3: seg_add(BYTE_FF);
         4: begin
            seg_add(BYTE_C2);
            seg_add(BYTE_AD);
         end
         5: begin
            seg_add(BYTE_E2);
            seg_add(BYTE_81);
            seg_add(BYTE_A0);
         end
         default: begin
            seg_add(BYTE_E2);
            seg_add(BYTE_80);
            seg_add(8'(BYTE_8B + $urandom_range(0, 2)));
         end
      endcase
   endtask

   // builds one stretch of text: plain bytes, newline runs, broken separators, long runs, noise
   task automatic build_segment();
      int unsigned pick;
      int unsigned i;
      int unsigned j;
      int unsigned n;
      logic [7:0]  bad;
      segment_bytes.delete();
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         n = $urandom_range(1, 6);
         for (i = 0; i < n; i++) seg_add(8'($urandom_range(8'h21, 8'h7E)));
      end else if (pick < 55) begin
         n = $urandom_range(1, 5);
         for (i = 0; i < n; i++) begin
            seg_add(any_newline());
            for (j = $urandom_range(0, 3); j > 0; j--) push_separator();
         end
         if ($urandom_range(0, 3) != 0) seg_add(8'($urandom_range(8'h21, 8'h7E)));
      end else if (pick < 65) begin
         seg_add(any_newline());
         if ($urandom_range(0, 1)) seg_add(any_newline());
         bad = ($urandom_range(0, 3) == 0) ? any_newline() : 8'($urandom_range(0, 255));
         case ($urandom_range(0, 3))
            0: begin
               seg_add(BYTE_C2);
               seg_add(bad == BYTE_AD ? BYTE_LF : bad);
            end
            1: begin
               seg_add(BYTE_E2);
               seg_add((bad == BYTE_80 || bad == BYTE_81) ? BYTE_SP : bad);
            end
            2: begin
               seg_add(BYTE_E2);
               seg_add(BYTE_80);
               seg_add((bad >= BYTE_8B && bad <= BYTE_8D) ? BYTE_CR : bad);
            end
            default: begin
               seg_add(BYTE_E2);
               seg_add(BYTE_81);
               seg_add(bad == BYTE_A0 ? 8'h41 : bad);
            end
         endcase
      end else if (pick < 75) begin
         // long run with at most two newlines, sized around the buffer depth
         seg_add(any_newline());
         n = $urandom_range(RUN_DEPTH - 6, RUN_DEPTH + 6);
         j = $urandom_range(0, 1) ? $urandom_range(0, n - 1) : n;
         for (i = 0; i < n; i++) begin
            if (i == j) seg_add(any_newline());
            if ($urandom_range(0, 3) == 0) push_separator();
            else seg_add(BYTE_SP);
         end
         seg_add(8'($urandom_range(8'h21, 8'h7E)));
      end else begin
         n = $urandom_range(1, 4);
         for (i = 0; i < n; i++) seg_add(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic run_phase(input logic enable, input int unsigned idle_pct,
                            input int unsigned stall_pct, input int unsigned count);
      int unsigned sent;
      int unsigned i;
      bit          end_here;
      write_enable(enable);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      sent = 0;
      while (sent < count) begin
         build_segment();
         end_here = $urandom_range(0, 5) == 0;
         for (i = 0; i < segment_bytes.size(); i++) begin
            send_word(segment_bytes[i], (end_here && i == segment_bytes.size() - 1) ||
                                        $urandom_range(0, 24) == 0);
            sent++;
         end
      end
      // leave a run pending across the register write
      send_word(BYTE_LF, 1'b0);
      drain();
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_data = 1'b0;
      words_in = 0;
      words_out = 0;
      csr_writes = 0;
      error_count = 0;
      cycle_count = 0;
      collapse_count = 0;
      overflow_count = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      typed_active = 0;
      typed_row = '0;
      clear_model();

      probe_table = '{
         '{8'h00,    1'b0, 1'b1, 2'd1, 24'h000000},
         '{8'hFF,    1'b0, 1'b1, 2'd1, 24'h0000FF},
         '{BYTE_LF,  1'b0, 1'b1, 2'd0, 24'h0},
         '{BYTE_CR,  1'b0, 1'b1, 2'd0, 24'h0},
         '{BYTE_SP,  1'b0, 1'b1, 2'd0, 24'h0},
         '{BYTE_LF,  1'b0, 1'b1, 2'd0, 24'h0},
         '{BYTE_TAB, 1'b0, 1'b1, 2'd0, 24'h0},
         '{8'h41,    1'b0, 1'b1, 2'd3, 24'h410A0A},
         '{BYTE_LF,  1'b1, 1'b1, 2'd1, 24'h00000A},
         '{BYTE_CR,  1'b0, 1'b0, 2'd0, 24'h0},
         '{BYTE_C2,  1'b0, 1'b0, 2'd0, 24'h0},
         '{BYTE_AD,  1'b0, 1'b0, 2'd0, 24'h0},
         '{BYTE_E2,  1'b0, 1'b0, 2'd0, 24'h0},
         '{BYTE_81,  1'b0, 1'b0, 2'd0, 24'h0},
         '{BYTE_A0,  1'b0, 1'b0, 2'd0, 24'h0},
         '{BYTE_E2,  1'b0, 1'b0, 2'd0, 24'h0},
         '{BYTE_80,  1'b0, 1'b0, 2'd0, 24'h0},
         '{BYTE_8B,  1'b0, 1'b0, 2'd0, 24'h0},
         '{BYTE_E2,  1'b0, 1'b0, 2'd0, 24'h0},
         '{BYTE_80,  1'b0, 1'b0, 2'd0, 24'h0},
         '{BYTE_LF,  1'b0, 1'b0, 2'd0, 24'h0},
         '{BYTE_E2,  1'b1, 1'b0, 2'd0, 24'h0},
         '{BYTE_C2,  1'b0, 1'b1, 2'd1, 24'h0000C2},
         '{BYTE_AD,  1'b1, 1'b1, 2'd1, 24'h0000AD}
      };

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table, register at its reset value
      typed_active = 1;
      foreach (probe_table[r]) begin
         typed_row = probe_table[r];
         send_word(probe_table[r].data, probe_table[r].last);
      end
      typed_active = 0;
      drain();

      run_phase(1'b1, 0,  0,  80);
      run_phase(1'b0, 86, 0,  35);
      run_phase(1'b1, 0,  86, 70);
      run_phase(1'b1, 28, 28, 60);
      run_phase(1'b0, 28, 28, 25);

      if (expected_words.size() != 0) begin
         $error("%0d expected output words never arrived", expected_words.size());
         error_count++;
      end
      $display("Sent %0d input words and checked %0d output words over five idle/stall phases.",
               words_in, words_out);
      $display("Runs collapsed: %0d, run buffer overflows: %0d, register writes: %0d.",
               collapse_count, overflow_count, csr_writes);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
